// File: design/rrts_pkg.sv
// shared types, codes and helpers of the round robin thread scheduler
`default_nettype none

package rrts_pkg;

   // default table size
   localparam int NUM_THREADS_DEF = 16;

   // command codes
   localparam logic [3:0] FN_CREATE    = 4'd0;
   localparam logic [3:0] FN_TERMINATE = 4'd1;
   localparam logic [3:0] FN_SUSPEND   = 4'd2;
   localparam logic [3:0] FN_RESUME    = 4'd3;
   localparam logic [3:0] FN_RESUME_F  = 4'd4;
   localparam logic [3:0] FN_SLEEP     = 4'd5;
   localparam logic [3:0] FN_WAKE      = 4'd6;
   localparam logic [3:0] FN_KILL      = 4'd7;
   localparam logic [3:0] FN_YIELD     = 4'd8;
   localparam logic [3:0] FN_YIELD_TO  = 4'd9;

   // result status codes
   localparam logic [1:0] RS_OK        = 2'd0;
   localparam logic [1:0] RS_FULL      = 2'd1;
   localparam logic [1:0] RS_NOT_LIVE  = 2'd2;
   localparam logic [1:0] RS_NOT_SLEEP = 2'd3;

   // slot state codes
   typedef enum logic [2:0] {
      TS_FREE    = 3'd0,
      TS_READY   = 3'd1,
      TS_SUSPEND = 3'd2,
      TS_SLEEP   = 3'd3,
      TS_TERM    = 3'd4,
      TS_CLEAR   = 3'd5
   } tstate_type;

   // one slot of the thread table
   typedef struct packed {
      tstate_type   state;
      logic [31:0]  wake;
      logic [7:0]   count;
      logic [15:0]  sig;
   } entry_type;

   // command word
   typedef struct packed {
      logic [3:0]   func;
      logic [3:0]   slot;
      logic [31:0]  now_ms;
      logic [31:0]  duration_ms;
      logic [15:0]  signal_value;
   } req_type;

   // result word
   typedef struct packed {
      logic [1:0]   status;
      logic [3:0]   new_slot;
      logic [3:0]   active_slot;
      logic         switched;
      logic         none_ready;
      logic [4:0]   ready_num;
      logic [4:0]   sleep_num;
      logic [15:0]  active_signal;
   } rsp_type;

   // datapath step ordered by the controller
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_CREATE,
      OP_TARGET,
      OP_RDCUR,
      OP_YCUR,
      OP_SCAN,
      OP_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } ctl_cmd_type;

   // datapath status seen by the controller
   typedef struct packed {
      logic [3:0] req_func;
      logic       req_slot_ok;
      logic [3:0] func;
      logic       clear_last;
      logic       tgt_free;
      logic       tgt_yield;
      logic       tgt_ready;
      logic       cur_ready;
      logic       cur_wakes;
      logic       create_done;
      logic       scan_stop;
      logic       rsp_busy;
   } dp_stat_type;

   // commands that name a target slot
   function automatic logic is_targeted(input logic [3:0] func);
      is_targeted = (func >= FN_TERMINATE) && (func <= FN_YIELD_TO) &&
                    (func != FN_SLEEP) && (func != FN_YIELD);
   endfunction

endpackage

`default_nettype wire

// File: design/rrts_if.sv
// command and result channel interfaces
`default_nettype none

interface rrts_req_if;
   logic              valid;
   logic              ready;
   rrts_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rrts_rsp_if;
   logic              valid;
   logic              ready;
   rrts_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/rrts_dpath.sv
// thread table, scheduler registers and result register
`default_nettype none

module rrts_dpath #(
   parameter int NUM_THREADS = rrts_pkg::NUM_THREADS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rrts_pkg::ctl_cmd_type cmd,
   output rrts_pkg::dp_stat_type      stat,
   input  wire rrts_pkg::req_type     req_data,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output rrts_pkg::rsp_type          rsp_data
);

   localparam int SW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
   localparam int CW = $clog2(NUM_THREADS + 1);
   localparam logic [SW-1:0] LAST = SW'(NUM_THREADS - 1);

   // table memory
   rrts_pkg::entry_type mem [NUM_THREADS];
   rrts_pkg::entry_type rd_ff;
   logic [SW-1:0]       rd_addr;
   logic                wr_en;
   logic [SW-1:0]       wr_addr;
   rrts_pkg::entry_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // registers
   rrts_pkg::req_type   req_ff, req_in;
   logic [SW-1:0]       cur_ff, cur_in;
   logic [SW-1:0]       before_ff, before_in;
   logic [SW-1:0]       idx_ff, idx_in;
   logic [SW-1:0]       k_ff, k_in;
   logic [SW-1:0]       new_slot_ff, new_slot_in;
   logic [1:0]          status_ff, status_in;
   logic [CW-1:0]       ready_ff, ready_in;
   logic [CW-1:0]       sleep_ff, sleep_in;
   logic                valid_ff, valid_in;
   rrts_pkg::rsp_type   out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         idx_ff   <= '0;
         ready_ff <= CW'(1);
         sleep_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         cur_ff   <= cur_in;
         idx_ff   <= idx_in;
         ready_ff <= ready_in;
         sleep_ff <= sleep_in;
         valid_ff <= valid_in;
      end
      req_ff      <= req_in;
      before_ff   <= before_in;
      k_ff        <= k_in;
      new_slot_ff <= new_slot_in;
      status_ff   <= status_in;
      out_ff      <= out_in;
   end

   function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
      next_slot = (s == LAST) ? '0 : s + SW'(1);
   endfunction

   // decode of the entry just read
   rrts_pkg::entry_type e;
   rrts_pkg::entry_type tgt_new;
   rrts_pkg::entry_type scan_new;
   rrts_pkg::entry_type ready_ent;
   logic                expired;
   logic [SW-1:0]       slot_sw;
   logic                slot_ok;
   logic [32:0]         wake_sum;
   logic [31:0]         wake_sat;
   logic                busy;

   assign e          = rd_ff;
   assign expired    = req_ff.now_ms >= e.wake;
   assign slot_sw    = SW'(req_ff.slot);
   assign slot_ok    = 32'(req_ff.slot) < 32'(NUM_THREADS);
   assign wake_sum   = {1'b0, req_ff.now_ms} + {1'b0, req_ff.duration_ms};
   assign wake_sat   = wake_sum[32] ? '1 : wake_sum[31:0];
   assign busy       = valid_ff && !rsp_ready;

   always_comb begin
      ready_ent       = e;
      ready_ent.state = rrts_pkg::TS_READY;
      ready_ent.wake  = '0;
   end

   // new entry of a targeted command
   always_comb begin
      tgt_new = e;
      unique case (req_ff.func)
         rrts_pkg::FN_TERMINATE: tgt_new.state = rrts_pkg::TS_TERM;
         rrts_pkg::FN_SUSPEND: begin
            if (e.count != 8'hFF) begin
               tgt_new.count = e.count + 8'd1;
            end
            tgt_new.state = rrts_pkg::TS_SUSPEND;
            tgt_new.wake  = '0;
         end
         rrts_pkg::FN_RESUME: begin
            if (e.count <= 8'd1) begin
               tgt_new       = ready_ent;
               tgt_new.count = '0;
            end else begin
               tgt_new.count = e.count - 8'd1;
            end
         end
         rrts_pkg::FN_RESUME_F: begin
            tgt_new       = ready_ent;
            tgt_new.count = '0;
         end
         rrts_pkg::FN_SLEEP: begin
            tgt_new.state = rrts_pkg::TS_SLEEP;
            tgt_new.wake  = wake_sat;
         end
         rrts_pkg::FN_WAKE: begin
            if (e.state == rrts_pkg::TS_SLEEP) begin
               tgt_new = ready_ent;
            end
         end
         rrts_pkg::FN_KILL: begin
            if (e.state == rrts_pkg::TS_SLEEP) begin
               tgt_new = ready_ent;
            end
            tgt_new.sig = req_ff.signal_value;
         end
         rrts_pkg::FN_YIELD_TO: begin
            if (e.state == rrts_pkg::TS_SLEEP && expired) begin
               tgt_new = ready_ent;
            end
         end
         default: tgt_new = e;
      endcase
   end

   // new entry of a slot visited by the round robin scan
   always_comb begin
      scan_new = e;
      if (e.state == rrts_pkg::TS_SLEEP && expired) begin
         scan_new = ready_ent;
      end else if (e.state == rrts_pkg::TS_CLEAR) begin
         scan_new = '0;
      end else if (e.state == rrts_pkg::TS_TERM) begin
         scan_new.state = rrts_pkg::TS_CLEAR;
      end
   end

   // status toward the controller
   always_comb begin
      stat.req_func    = req_data.func;
      stat.req_slot_ok = 32'(req_data.slot) < 32'(NUM_THREADS);
      stat.func        = req_ff.func;
      stat.clear_last  = idx_ff == LAST;
      stat.tgt_free    = e.state == rrts_pkg::TS_FREE;
      stat.tgt_yield   = (req_ff.func == rrts_pkg::FN_SUSPEND) && (slot_sw == cur_ff);
      stat.tgt_ready   = tgt_new.state == rrts_pkg::TS_READY;
      stat.cur_ready   = e.state == rrts_pkg::TS_READY;
      stat.cur_wakes   = e.state == rrts_pkg::TS_SLEEP && expired;
      stat.create_done = (e.state == rrts_pkg::TS_FREE) || (idx_ff == LAST);
      stat.scan_stop   = (scan_new.state == rrts_pkg::TS_READY) || (k_ff == LAST);
      stat.rsp_busy    = busy;
   end

   // step logic
   always_comb begin
      rd_addr     = cur_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = e;
      req_in      = req_ff;
      cur_in      = cur_ff;
      before_in   = before_ff;
      idx_in      = idx_ff;
      k_in        = k_ff;
      new_slot_in = new_slot_ff;
      status_in   = status_ff;
      ready_in    = ready_ff;
      sleep_in    = sleep_ff;
      valid_in    = valid_ff && !rsp_ready;
      out_in      = out_ff;

      unique case (cmd.op)
         rrts_pkg::OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            if (idx_ff == '0) begin
               wr_data.state = rrts_pkg::TS_READY;
            end
            idx_in = next_slot(idx_ff);
         end
         rrts_pkg::OP_ACCEPT: begin
            req_in      = req_data;
            before_in   = cur_ff;
            new_slot_in = '0;
            idx_in      = '0;
            status_in   = (rrts_pkg::is_targeted(req_data.func) &&
                           !stat.req_slot_ok) ? rrts_pkg::RS_NOT_LIVE : rrts_pkg::RS_OK;
            if (req_data.func == rrts_pkg::FN_CREATE) begin
               rd_addr = '0;
            end else if (rrts_pkg::is_targeted(req_data.func) && stat.req_slot_ok) begin
               rd_addr = SW'(req_data.slot);
            end
         end
         rrts_pkg::OP_CREATE: begin
            if (e.state == rrts_pkg::TS_FREE) begin
               wr_en         = 1'b1;
               wr_data       = '0;
               wr_data.state = rrts_pkg::TS_READY;
               new_slot_in   = idx_ff;
            end else if (idx_ff == LAST) begin
               status_in = rrts_pkg::RS_FULL;
            end else begin
               idx_in  = next_slot(idx_ff);
               rd_addr = next_slot(idx_ff);
            end
         end
         rrts_pkg::OP_TARGET: begin
            if (rrts_pkg::is_targeted(req_ff.func) && e.state == rrts_pkg::TS_FREE) begin
               status_in = rrts_pkg::RS_NOT_LIVE;
            end else if (slot_ok || req_ff.func == rrts_pkg::FN_SLEEP) begin
               wr_en   = 1'b1;
               wr_addr = (req_ff.func == rrts_pkg::FN_SLEEP) ? cur_ff : slot_sw;
               wr_data = tgt_new;
               if (req_ff.func == rrts_pkg::FN_WAKE && e.state != rrts_pkg::TS_SLEEP) begin
                  status_in = rrts_pkg::RS_NOT_SLEEP;
               end
               if (req_ff.func == rrts_pkg::FN_YIELD_TO &&
                   tgt_new.state == rrts_pkg::TS_READY) begin
                  cur_in = slot_sw;
               end
            end
         end
         rrts_pkg::OP_YCUR: begin
            if (stat.cur_wakes) begin
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = ready_ent;
            end else begin
               idx_in  = next_slot(cur_ff);
               k_in    = SW'(1);
               rd_addr = next_slot(cur_ff);
            end
         end
         rrts_pkg::OP_SCAN: begin
            wr_en   = 1'b1;
            wr_data = scan_new;
            if (scan_new.state == rrts_pkg::TS_READY) begin
               cur_in = idx_ff;
            end else begin
               idx_in  = next_slot(idx_ff);
               k_in    = k_ff + SW'(1);
               rd_addr = next_slot(idx_ff);
            end
         end
         rrts_pkg::OP_LOAD: begin
            if (!busy) begin
               valid_in             = 1'b1;
               out_in.status        = status_ff;
               out_in.new_slot      = 4'(new_slot_ff);
               out_in.active_slot   = 4'(cur_ff);
               out_in.switched      = cur_ff != before_ff;
               out_in.none_ready    = ready_ff == '0;
               out_in.ready_num     = (32'(ready_ff) > 32'd31) ? 5'd31 : 5'(ready_ff);
               out_in.sleep_num     = (32'(sleep_ff) > 32'd31) ? 5'd31 : 5'(sleep_ff);
               out_in.active_signal = e.sig;
            end
         end
         rrts_pkg::OP_RDCUR,
         rrts_pkg::OP_IDLE: begin
            rd_addr = cur_ff;
         end
         default: rd_addr = cur_ff;
      endcase

      // ready and sleep totals follow every state change outside the clearing pass
      if (wr_en && cmd.op != rrts_pkg::OP_CLEAR && e.state != wr_data.state) begin
         if (e.state == rrts_pkg::TS_READY) begin
            ready_in = ready_ff - CW'(1);
         end else if (wr_data.state == rrts_pkg::TS_READY) begin
            ready_in = ready_ff + CW'(1);
         end
         if (e.state == rrts_pkg::TS_SLEEP) begin
            sleep_in = sleep_ff - CW'(1);
         end else if (wr_data.state == rrts_pkg::TS_SLEEP) begin
            sleep_in = sleep_ff + CW'(1);
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// File: design/rrts_ctrl.sv
// command sequencer of the round robin thread scheduler
`default_nettype none

module rrts_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire rrts_pkg::dp_stat_type stat,
   output rrts_pkg::ctl_cmd_type      cmd
);

   typedef enum logic [9:0] {
      CS_CLEAR  = 10'b00_0000_0001,
      CS_IDLE   = 10'b00_0000_0010,
      CS_CREATE = 10'b00_0000_0100,
      CS_TARGET = 10'b00_0000_1000,
      CS_YREAD  = 10'b00_0001_0000,
      CS_YCUR   = 10'b00_0010_0000,
      CS_Y9CHK  = 10'b00_0100_0000,
      CS_SCAN   = 10'b00_1000_0000,
      CS_FIN    = 10'b01_0000_0000,
      CS_LOAD   = 10'b10_0000_0000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == CS_IDLE;

   // next state and datapath step
   always_comb begin
      state_in = state_ff;
      cmd.op   = rrts_pkg::OP_IDLE;
      unique case (state_ff)
         CS_CLEAR: begin
            cmd.op = rrts_pkg::OP_CLEAR;
            if (stat.clear_last) begin
               state_in = CS_IDLE;
            end
         end
         CS_IDLE: begin
            if (req_valid) begin
               cmd.op = rrts_pkg::OP_ACCEPT;
               priority if (stat.req_func == rrts_pkg::FN_CREATE) begin
                  state_in = CS_CREATE;
               end else if (stat.req_func == rrts_pkg::FN_SLEEP) begin
                  state_in = CS_TARGET;
               end else if (stat.req_func == rrts_pkg::FN_YIELD) begin
                  state_in = CS_YCUR;
               end else if (rrts_pkg::is_targeted(stat.req_func) && stat.req_slot_ok) begin
                  state_in = CS_TARGET;
               end else begin
                  state_in = CS_FIN;
               end
            end
         end
         CS_CREATE: begin
            cmd.op = rrts_pkg::OP_CREATE;
            if (stat.create_done) begin
               state_in = CS_FIN;
            end
         end
         CS_TARGET: begin
            cmd.op = rrts_pkg::OP_TARGET;
            priority if (rrts_pkg::is_targeted(stat.func) && stat.tgt_free) begin
               state_in = CS_FIN;
            end else if (stat.func == rrts_pkg::FN_SLEEP || stat.tgt_yield) begin
               state_in = CS_YREAD;
            end else if (stat.func == rrts_pkg::FN_YIELD_TO && !stat.tgt_ready) begin
               state_in = CS_YREAD;
            end else begin
               state_in = CS_FIN;
            end
         end
         CS_YREAD: begin
            cmd.op   = rrts_pkg::OP_RDCUR;
            state_in = (stat.func == rrts_pkg::FN_YIELD_TO) ? CS_Y9CHK : CS_YCUR;
         end
         CS_YCUR: begin
            cmd.op   = rrts_pkg::OP_YCUR;
            state_in = stat.cur_wakes ? CS_FIN : CS_SCAN;
         end
         CS_Y9CHK: begin
            if (stat.cur_ready) begin
               cmd.op   = rrts_pkg::OP_RDCUR;
               state_in = CS_LOAD;
            end else begin
               cmd.op   = rrts_pkg::OP_YCUR;
               state_in = stat.cur_wakes ? CS_FIN : CS_SCAN;
            end
         end
         CS_SCAN: begin
            cmd.op = rrts_pkg::OP_SCAN;
            if (stat.scan_stop) begin
               state_in = CS_FIN;
            end
         end
         CS_FIN: begin
            cmd.op   = rrts_pkg::OP_RDCUR;
            state_in = CS_LOAD;
         end
         CS_LOAD: begin
            cmd.op = rrts_pkg::OP_LOAD;
            if (!stat.rsp_busy) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
            cmd.op   = rrts_pkg::OP_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: design/round_robin_thread_scheduler.sv
// top level of the round robin thread scheduler
// Takes one command word at a time and returns exactly one result word for
// it. The thread table sits in a memory with a registered read port and a
// separate write port. An unknown command or an out-of-range slot goes from
// acceptance straight to the final read and the load of the result word; the
// other simple commands first step once on their target slot, create walks
// the table for a free slot, and a plain yield, a sleep, a suspend of the
// active slot or a yield_to whose target and active slot are not ready may go
// on to the round robin walk of one slot per cycle. The next command is taken
// in the cycle after the result is loaded; while the previous result still
// waits in the output register the load waits for it.
// After reset a clearing pass over all NUM_THREADS slots initializes the
// table; no command is taken until it ends.
`default_nettype none

module round_robin_thread_scheduler #(
   parameter int NUM_THREADS = rrts_pkg::NUM_THREADS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rrts_req_if.sink    req_if,
   rrts_rsp_if.source  rsp_if
);

   rrts_pkg::ctl_cmd_type cmd;
   rrts_pkg::dp_stat_type stat;
   logic                  req_ready;

   // sequencer
   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table and registers
   rrts_dpath #(
      .NUM_THREADS (NUM_THREADS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_if.data),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_data  (rsp_if.data)
   );

   assign req_if.ready = req_ready;

endmodule

`default_nettype wire

// File: bench/tb_seq.sv
// stimulus generation helpers for the scheduler testbench
`timescale 1ns / 1ps

package tb_seq_pkg;

   // build one command word
   function automatic rrts_pkg::req_type make_cmd(input logic [3:0] func,
                                                  input logic [3:0] slot,
                                                  input logic [31:0] now_ms,
                                                  input logic [31:0] duration_ms,
                                                  input logic [15:0] signal_value);
      rrts_pkg::req_type r;
      r.func = func;
      r.slot = slot;
      r.now_ms = now_ms;
      r.duration_ms = duration_ms;
      r.signal_value = signal_value;
      return r;
   endfunction
endpackage

// File: bench/tb.sv
// testbench of the round robin thread scheduler: self-checking with its own predictor
`timescale 1ns / 1ps

module tb;

   localparam int NT = 16;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rrts_req_if req_ch ();
   rrts_rsp_if rsp_ch ();

   round_robin_thread_scheduler #(.NUM_THREADS(NT)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   always #2 clock = ~clock;

   // predictor state of the thread table
   rrts_pkg::tstate_type tbl_state [NT];
   logic [31:0] tbl_wake [NT];
   logic [7:0]  tbl_count [NT];
   logic [15:0] tbl_sig [NT];
   logic [3:0]  run_slot;
   int          n_ready;
   int          n_sleep;

   rrts_pkg::rsp_type expected_words [$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      hold_cycles = 0;
   int      quiet_cycles = 0;
   logic    recv_ready = 1'b0;

   // state change with ready and sleep bookkeeping
   function automatic void put_state(input int s, input rrts_pkg::tstate_type ns);
      rrts_pkg::tstate_type os;
      os = tbl_state[s];
      if (os == ns) return;
      tbl_state[s] = ns;
      if (os == rrts_pkg::TS_READY) n_ready--;
      else if (ns == rrts_pkg::TS_READY) n_ready++;
      if (os == rrts_pkg::TS_SLEEP) n_sleep--;
      else if (ns == rrts_pkg::TS_SLEEP) n_sleep++;
   endfunction

   function automatic void wake_slot(input int s);
      put_state(s, rrts_pkg::TS_READY);
      tbl_wake[s] = '0;
   endfunction

   function automatic void release_slot(input int s);
      put_state(s, rrts_pkg::TS_FREE);
      tbl_wake[s] = '0;
      tbl_count[s] = '0;
      tbl_sig[s] = '0;
   endfunction

   function automatic void reset_table();
      for (int i = 0; i < NT; i++) begin
         tbl_state[i] = rrts_pkg::TS_FREE;
         tbl_wake[i] = '0;
         tbl_count[i] = '0;
         tbl_sig[i] = '0;
      end
      tbl_state[0] = rrts_pkg::TS_READY;
      run_slot = '0;
      n_ready = 1;
      n_sleep = 0;
   endfunction

   // walk of the slots after the running one
   function automatic void pick_next(input logic [31:0] now_ms);
      int s;
      if (tbl_state[run_slot] == rrts_pkg::TS_SLEEP && now_ms >= tbl_wake[run_slot]) begin
         wake_slot(int'(run_slot));
         return;
      end
      for (int k = 1; k < NT; k++) begin
         s = (int'(run_slot) + k) % NT;
         if (tbl_state[s] == rrts_pkg::TS_SLEEP && now_ms >= tbl_wake[s]) wake_slot(s);
         else if (tbl_state[s] == rrts_pkg::TS_CLEAR) release_slot(s);
         else if (tbl_state[s] == rrts_pkg::TS_TERM) put_state(s, rrts_pkg::TS_CLEAR);
         if (tbl_state[s] == rrts_pkg::TS_READY) begin
            run_slot = 4'(s);
            return;
         end
      end
   endfunction

   // expected result of one command
   function automatic rrts_pkg::rsp_type schedule_cmd(input rrts_pkg::req_type c);
      rrts_pkg::rsp_type r;
      logic [3:0] prev;
      logic [32:0] sum;
      int t;
      bit live;
      r = '0;
      prev = run_slot;
      t = int'(c.slot);
      live = tbl_state[t] != rrts_pkg::TS_FREE;
      if (rrts_pkg::is_targeted(c.func) && !live) begin
         r.status = rrts_pkg::RS_NOT_LIVE;
      end else begin
         unique case (c.func)
            rrts_pkg::FN_CREATE: begin
               r.status = rrts_pkg::RS_FULL;
               for (int s = 0; s < NT; s++) begin
                  if (tbl_state[s] == rrts_pkg::TS_FREE) begin
                     release_slot(s);
                     put_state(s, rrts_pkg::TS_READY);
                     r.new_slot = 4'(s);
                     r.status = rrts_pkg::RS_OK;
                     break;
                  end
               end
            end
            rrts_pkg::FN_TERMINATE: put_state(t, rrts_pkg::TS_TERM);
            rrts_pkg::FN_SUSPEND: begin
               if (tbl_count[t] != 8'hff) tbl_count[t]++;
               put_state(t, rrts_pkg::TS_SUSPEND);
               tbl_wake[t] = '0;
               if (t == int'(run_slot)) pick_next(c.now_ms);
            end
            rrts_pkg::FN_RESUME: begin
               if (tbl_count[t] <= 8'd1) begin
                  wake_slot(t);
                  tbl_count[t] = '0;
               end else begin
                  tbl_count[t]--;
               end
            end
            rrts_pkg::FN_RESUME_F: begin
               tbl_count[t] = '0;
               wake_slot(t);
            end
            rrts_pkg::FN_SLEEP: begin
               sum = {1'b0, c.now_ms} + {1'b0, c.duration_ms};
               tbl_wake[run_slot] = sum[32] ? 32'hffff_ffff : sum[31:0];
               put_state(int'(run_slot), rrts_pkg::TS_SLEEP);
               pick_next(c.now_ms);
            end
            rrts_pkg::FN_WAKE: begin
               if (tbl_state[t] == rrts_pkg::TS_SLEEP) wake_slot(t);
               else r.status = rrts_pkg::RS_NOT_SLEEP;
            end
            rrts_pkg::FN_KILL: begin
               tbl_sig[t] = c.signal_value;
               if (tbl_state[t] == rrts_pkg::TS_SLEEP) wake_slot(t);
            end
            rrts_pkg::FN_YIELD: pick_next(c.now_ms);
            rrts_pkg::FN_YIELD_TO: begin
               if (tbl_state[t] == rrts_pkg::TS_SLEEP && c.now_ms >= tbl_wake[t])
                  wake_slot(t);
               if (tbl_state[t] == rrts_pkg::TS_READY) run_slot = 4'(t);
               else if (tbl_state[run_slot] != rrts_pkg::TS_READY) pick_next(c.now_ms);
            end
            default: ;
         endcase
      end
      r.active_slot = run_slot;
      r.switched = run_slot != prev;
      r.none_ready = n_ready == 0;
      r.ready_num = (n_ready > 31) ? 5'd31 : 5'(n_ready);
      r.sleep_num = (n_sleep > 31) ? 5'd31 : 5'(n_sleep);
      r.active_signal = tbl_sig[run_slot];
      return r;
   endfunction

   // send one command word with random gaps
   task automatic send_cmd(input rrts_pkg::req_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_words.push_back(schedule_cmd(c));
   endtask

   task automatic send(input logic [3:0] f, input logic [3:0] s, input logic [31:0] n,
                       input logic [31:0] d, input logic [15:0] g);
      send_cmd(tb_seq_pkg::make_cmd(f, s, n, d, g));
   endtask

   // receiver ready with random stalls and a long hold-off
   always @(posedge clock) begin
      if (reset) begin
         recv_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         recv_ready <= 1'b0;
      end else begin
         recv_ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end
   assign rsp_ch.ready = recv_ready;

   // result checker
   always @(posedge clock) begin
      rrts_pkg::rsp_type e;
      rrts_pkg::rsp_type a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a = rsp_ch.data;
         if (expected_words.size() == 0) begin
            $display("%t unexpected result word %h", $time, a);
            error_count++;
         end else begin
            e = expected_words.pop_front();
            if (a.status !== e.status) begin
               $display("%t status exp %0d got %0d", $time, e.status, a.status);
               error_count++;
            end
            if (a.new_slot !== e.new_slot) begin
               $display("%t new_slot exp %0d got %0d", $time, e.new_slot, a.new_slot);
               error_count++;
            end
            if (a.active_slot !== e.active_slot) begin
               $display("%t active_slot exp %0d got %0d", $time, e.active_slot,
                        a.active_slot);
               error_count++;
            end
            if (a.switched !== e.switched) begin
               $display("%t switched exp %0d got %0d", $time, e.switched, a.switched);
               error_count++;
            end
            if (a.none_ready !== e.none_ready) begin
               $display("%t none_ready exp %0d got %0d", $time, e.none_ready,
                        a.none_ready);
               error_count++;
            end
            if (a.ready_num !== e.ready_num) begin
               $display("%t ready_num exp %0d got %0d", $time, e.ready_num,
                        a.ready_num);
               error_count++;
            end
            if (a.sleep_num !== e.sleep_num) begin
               $display("%t sleep_num exp %0d got %0d", $time, e.sleep_num,
                        a.sleep_num);
               error_count++;
            end
            if (a.active_signal !== e.active_signal) begin
               $display("%t active_signal exp %h got %h", $time, e.active_signal,
                        a.active_signal);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // directed: extremes, every command and the special cases
   task automatic test_directed();
      send(rrts_pkg::FN_YIELD, 4'd0, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_TERMINATE, 4'd15, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_CREATE, 4'd0, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_CREATE, 4'd0, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_KILL, 4'd1, 32'd0, 32'd0, 16'hffff);
      send(rrts_pkg::FN_SLEEP, 4'd0, 32'hffff_fff0, 32'hffff_ffff, 16'd0);
      send(rrts_pkg::FN_WAKE, 4'd0, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_WAKE, 4'd0, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_SUSPEND, 4'd1, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_SUSPEND, 4'd1, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_RESUME, 4'd1, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_RESUME, 4'd1, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_SLEEP, 4'd0, 32'd100, 32'd50, 16'd0);
      send(rrts_pkg::FN_YIELD_TO, 4'd0, 32'd149, 32'd0, 16'd0);
      send(rrts_pkg::FN_YIELD_TO, 4'd0, 32'd150, 32'd0, 16'd0);
      send(rrts_pkg::FN_SUSPEND, 4'd2, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_RESUME_F, 4'd2, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_TERMINATE, 4'd2, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_YIELD, 4'd0, 32'd0, 32'd0, 16'd0);
      send(rrts_pkg::FN_YIELD, 4'd0, 32'd0, 32'd0, 16'd0);
      for (int i = 0; i < 16; i++) send(rrts_pkg::FN_CREATE, 4'd0, 32'd0, 32'd0, 16'd0);
      send(4'd15, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
   endtask

   // random commands weighted toward slots 0 to 5
   task automatic test_random(input int count);
      logic [3:0] f;
      logic [3:0] s;
      logic [31:0] n;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 12) f = rrts_pkg::FN_CREATE;
         else if (pick < 20) f = rrts_pkg::FN_TERMINATE;
         else if (pick < 30) f = rrts_pkg::FN_SUSPEND;
         else if (pick < 40) f = rrts_pkg::FN_RESUME;
         else if (pick < 45) f = rrts_pkg::FN_RESUME_F;
         else if (pick < 55) f = rrts_pkg::FN_SLEEP;
         else if (pick < 62) f = rrts_pkg::FN_WAKE;
         else if (pick < 68) f = rrts_pkg::FN_KILL;
         else if (pick < 82) f = rrts_pkg::FN_YIELD;
         else if (pick < 95) f = rrts_pkg::FN_YIELD_TO;
         else f = 4'($urandom_range(15, 10));
         s = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(5));
         n = ($urandom_range(9) == 0) ? $urandom : $urandom_range(2000);
         send(f, s, n, ($urandom_range(9) == 0) ? $urandom : $urandom_range(300),
              16'($urandom));
      end
   endtask

   // receiver held off long while commands keep coming
   task automatic test_backpressure();
      hold_cycles = 400;
      test_random(30);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      reset_table();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(250);
      send_idle_pct = 45;
      test_random(250);
      send_idle_pct = 0;
      recv_stall_pct = 45;
      test_random(250);
      send_idle_pct = 8;
      recv_stall_pct = 8;
      test_random(250);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_backpressure();
      drain();
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
design/rrts_pkg.sv
design/rrts_if.sv
design/rrts_dpath.sv
design/rrts_ctrl.sv
design/round_robin_thread_scheduler.sv
bench/tb_seq.sv
bench/tb.sv
